>>> rtl/pcm_voice_mixer_core_defines.svh
// ---------------------------------------------------------------------------
// pcm voice mixer assertion macros
// shared property forms for the mixer core checks
// ---------------------------------------------------------------------------
`ifndef PCM_VOICE_MIXER_CORE_DEFINES_SVH
`define PCM_VOICE_MIXER_CORE_DEFINES_SVH

// same-cycle implication
`define PVM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvm check failed");

// next-cycle implication
`define PVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvm check failed");

`endif

>>> rtl/pvm_pkg.sv
// ---------------------------------------------------------------------------
// pvm_pkg
// shared types and constants of the pcm voice mixer
// ---------------------------------------------------------------------------
package pvm_pkg;

   localparam int VOICES      = 8;
   localparam int VOICE_BITS  = 3;
   localparam int ADDR_BITS   = 16;
   localparam int WORD_BITS   = 16;
   localparam int STEP_BITS   = 20;
   localparam int DIV_STEPS   = 33;
   localparam int DCNT_BITS   = 6;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_START  = 3'd1,
      OP_VOLUME = 3'd2,
      OP_STOP   = 3'd3,
      OP_QUERY  = 3'd4,
      OP_MIX    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_VOICE = 2'd1,
      ST_BAD_HDR  = 2'd2,
      ST_BAD_RATE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CHECK, S_DIV, S_COMMIT, S_MIX_CHECK, S_MIX_ACC, S_RESP
   } state_type;

   typedef struct packed {
      logic                  capture;
      logic                  load;
      logic                  volume;
      logic                  stop;
      logic                  query;
      logic                  check;
      logic                  div_step;
      logic                  commit;
      logic                  mix_check;
      logic                  mix_acc;
      logic [VOICE_BITS-1:0] voice;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       check_fail;
      logic       voice_live;
      logic       voice_done;
   } sts_type;

endpackage

>>> rtl/pvm_datapath.sv
// ---------------------------------------------------------------------------
// pvm_datapath
// request capture, sample store, voice table, step divider and mix accumulator
// ---------------------------------------------------------------------------
module pvm_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  pvm_pkg::cmd_type            cmd,
   output pvm_pkg::sts_type            sts,
   input  logic                        csr_write_enable,
   input  logic [15:0]                 csr_write_data,
   input  logic [2:0]                  req_operation,
   input  logic [3:0]                  req_channel,
   input  logic [15:0]                 req_sample_address,
   input  logic [7:0]                  req_sample_byte,
   input  logic [15:0]                 req_lump_length,
   input  logic [15:0]                 req_format,
   input  logic [15:0]                 req_dmx_length,
   input  logic [15:0]                 req_source_rate,
   input  logic [7:0]                  req_pitch,
   input  logic [7:0]                  req_volume,
   output logic signed [15:0]          rsp_left_sample,
   output logic signed [15:0]          rsp_right_sample,
   output logic [1:0]                  rsp_status,
   output logic [2:0]                  rsp_assigned_channel,
   output logic                        rsp_playing
);
   import pvm_pkg::*;

   // captured request
   logic [2:0]           op_ff;
   logic [3:0]           chan_ff;
   logic [15:0]          addr_ff, lump_ff, fmt_ff, dlen_ff, rate_ff;
   logic [7:0]           byte_ff, pitch_ff, vol_ff;
   logic [15:0]          out_rate_ff;

   // voice table
   logic [VOICES-1:0]    active_ff;
   logic [31:0]          pos_ff   [VOICES];
   logic [STEP_BITS-1:0] step_ff  [VOICES];
   logic [15:0]          count_ff [VOICES];
   logic [15:0]          base_ff  [VOICES];
   logic [7:0]           vvol_ff  [VOICES];

   // sample store
   logic [7:0]           store [2**ADDR_BITS];
   logic [7:0]           rd_ff;
   logic [ADDR_BITS-1:0] rd_addr;

   // divider and result
   logic [15:0]          rem_ff;
   logic [32:0]          quo_ff;
   logic [VOICE_BITS-1:0] pick_ff;
   logic signed [15:0]   sum_ff;
   logic [1:0]           status_ff;
   logic [2:0]           assigned_ff;
   logic                 playing_ff;

   logic [VOICE_BITS-1:0] lowest;
   logic [VOICE_BITS-1:0] pick;
   logic                  no_voice, bad_hdr, bad_rate;
   logic [1:0]            check_status;
   logic [15:0]           divisor;
   logic [16:0]           trial;
   logic                  trial_ge;
   logic [23:0]           rate_prod;
   logic [STEP_BITS-1:0]  step_val;
   logic signed [8:0]     centred;
   logic signed [17:0]    scaled;
   logic signed [18:0]    acc;
   logic signed [15:0]    acc_sat;
   logic [VOICE_BITS-1:0] v;

   function automatic logic [7:0] pitch_eff(input logic [7:0] p);
      pitch_eff = (p == 8'd0) ? 8'd128 : p;
   endfunction

   assign v = cmd.voice;

   always_comb begin
      lowest = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) lowest = VOICE_BITS'(i);
      end
   end

   assign pick     = chan_ff[3] ? lowest : chan_ff[VOICE_BITS-1:0];
   assign no_voice = chan_ff[3] && (&active_ff);
   assign bad_hdr  = (lump_ff < 16'd8) || (fmt_ff != 16'd3) ||
                     (dlen_ff > (lump_ff - 16'd8)) || (dlen_ff < 16'd49);
   assign bad_rate = (rate_ff == 16'd0) || (rate_ff > 16'd48000);

   always_comb begin
      priority if (no_voice) check_status = ST_NO_VOICE;
      else if (bad_hdr)      check_status = ST_BAD_HDR;
      else if (bad_rate)     check_status = ST_BAD_RATE;
      else                   check_status = ST_OK;
   end

   // restoring divider, one quotient bit a cycle
   assign divisor   = (out_rate_ff == 16'd0) ? 16'd1 : out_rate_ff;
   assign rate_prod = 24'(rate_ff) * 24'(pitch_eff(pitch_ff));
   assign trial     = {rem_ff, quo_ff[32]};
   assign trial_ge  = trial >= {1'b0, divisor};

   always_comb begin
      priority if (quo_ff == 33'd0)          step_val = STEP_BITS'(1);
      else if (quo_ff > 33'hF_FFFF)          step_val = '1;
      else                                   step_val = quo_ff[STEP_BITS-1:0];
   end

   // mix arithmetic: (byte - 128) * volume is exact for the scaled form
   assign rd_addr = base_ff[v] + pos_ff[v][31:16];
   assign centred = $signed({1'b0, rd_ff}) - 9'sd128;
   assign scaled  = centred * $signed({1'b0, vvol_ff[v]});
   assign acc     = 19'(sum_ff) + 19'(scaled);

   always_comb begin
      priority if (acc > 19'sd32767)  acc_sat = 16'sh7FFF;
      else if (acc < -19'sd32768)     acc_sat = -16'sh8000;
      else                            acc_sat = acc[15:0];
   end

   assign sts.op         = op_ff;
   assign sts.check_fail = check_status != ST_OK;
   assign sts.voice_live = active_ff[v];
   assign sts.voice_done = pos_ff[v][31:16] >= count_ff[v];

   always_ff @(posedge clock) begin
      if (cmd.load) store[addr_ff] <= byte_ff;
      rd_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_rate_ff <= 16'd22050;
         active_ff   <= '0;
      end else begin
         if (csr_write_enable) out_rate_ff <= csr_write_data;
         if (cmd.stop && !chan_ff[3]) active_ff[chan_ff[VOICE_BITS-1:0]] <= 1'b0;
         if (cmd.commit) active_ff[pick_ff] <= 1'b1;
         if (cmd.mix_check && active_ff[v] && sts.voice_done) active_ff[v] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         chan_ff     <= req_channel;
         addr_ff     <= req_sample_address;
         byte_ff     <= req_sample_byte;
         lump_ff     <= req_lump_length;
         fmt_ff      <= req_format;
         dlen_ff     <= req_dmx_length;
         rate_ff     <= req_source_rate;
         pitch_ff    <= req_pitch;
         vol_ff      <= req_volume;
         sum_ff      <= '0;
         status_ff   <= ST_OK;
         assigned_ff <= '0;
         playing_ff  <= 1'b0;
      end
      if (cmd.volume && !chan_ff[3]) vvol_ff[chan_ff[VOICE_BITS-1:0]] <= vol_ff;
      if (cmd.query) playing_ff <= !chan_ff[3] && active_ff[chan_ff[VOICE_BITS-1:0]];
      if (cmd.check) begin
         status_ff <= check_status;
         pick_ff   <= pick;
         rem_ff    <= '0;
         quo_ff    <= {rate_prod[23:7], 16'd0};
      end
      if (cmd.div_step) begin
         rem_ff <= trial_ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
         quo_ff <= {quo_ff[31:0], trial_ge};
      end
      if (cmd.commit) begin
         base_ff[pick_ff]  <= addr_ff + 16'd24;
         count_ff[pick_ff] <= dlen_ff - 16'd32;
         pos_ff[pick_ff]   <= '0;
         step_ff[pick_ff]  <= step_val;
         vvol_ff[pick_ff]  <= vol_ff;
         assigned_ff       <= pick_ff;
      end
      if (cmd.mix_acc) begin
         sum_ff    <= acc_sat;
         pos_ff[v] <= pos_ff[v] + 32'(step_ff[v]);
      end
   end

   assign rsp_left_sample      = sum_ff;
   assign rsp_right_sample     = sum_ff;
   assign rsp_status           = status_ff;
   assign rsp_assigned_channel = assigned_ff;
   assign rsp_playing          = playing_ff;

endmodule

>>> rtl/pvm_ctrl.sv
// ---------------------------------------------------------------------------
// pvm_ctrl
// sequencer for decode, start checks, step division and the voice sweep
// ---------------------------------------------------------------------------
module pvm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output pvm_pkg::cmd_type cmd,
   input  pvm_pkg::sts_type sts
);
   import pvm_pkg::*;

   state_type              state_ff, state_in;
   logic [VOICE_BITS-1:0]  voice_ff, voice_in;
   logic [DCNT_BITS-1:0]   dcnt_ff, dcnt_in;
   logic                   last_voice;

   assign last_voice = voice_ff == VOICE_BITS'(VOICES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         voice_ff <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         voice_ff <= voice_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      voice_in = voice_ff;
      dcnt_in  = dcnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            voice_in = '0;
            dcnt_in  = '0;
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (sts.op)
               OP_START: state_in = S_CHECK;
               OP_MIX:   state_in = S_MIX_CHECK;
               default:  state_in = S_RESP;
            endcase
         end
         S_CHECK: state_in = sts.check_fail ? S_RESP : S_DIV;
         S_DIV: begin
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_BITS'(DIV_STEPS - 1)) state_in = S_COMMIT;
         end
         S_COMMIT: state_in = S_RESP;
         S_MIX_CHECK: begin
            if (sts.voice_live && !sts.voice_done) state_in = S_MIX_ACC;
            else if (last_voice) state_in = S_RESP;
            else voice_in = voice_ff + 1'b1;
         end
         S_MIX_ACC: begin
            if (last_voice) state_in = S_RESP;
            else begin
               state_in = S_MIX_CHECK;
               voice_in = voice_ff + 1'b1;
            end
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.voice = voice_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_DECODE: begin
            unique case (sts.op)
               OP_LOAD:   cmd.load   = 1'b1;
               OP_VOLUME: cmd.volume = 1'b1;
               OP_STOP:   cmd.stop   = 1'b1;
               OP_QUERY:  cmd.query  = 1'b1;
               default:   ;
            endcase
         end
         S_CHECK:     cmd.check     = 1'b1;
         S_DIV:       cmd.div_step  = 1'b1;
         S_COMMIT:    cmd.commit    = 1'b1;
         S_MIX_CHECK: cmd.mix_check = 1'b1;
         S_MIX_ACC:   cmd.mix_acc   = 1'b1;
         S_RESP:      rsp_valid     = 1'b1;
         default:     ;
      endcase
   end

endmodule

>>> rtl/pcm_voice_mixer_core.sv
// ---------------------------------------------------------------------------
// pcm_voice_mixer_core
// eight-voice pcm sample player and mixer with a 64k byte sample store
// ---------------------------------------------------------------------------
// channel   handshake                 payload
// req       start in, busy out        req_operation .. req_volume
// rsp       rsp_valid strobe out      rsp_left_sample .. rsp_playing
// csr       csr_write_enable in       csr_write_data (output rate)
//
// one item at a time; busy is high from the accepting edge until the strobe
// load, volume, stop, query and unused codes: a decode step, then the strobe
// start: a check step, then the strobe on a failure, else step divider and commit
// mix tick: a check step for every voice plus a store-read accumulate step per sounding voice
// synchronous reset clears the voice active bits and the sequencer; no store
// clearing pass. the receiver cannot stall: each result shows for one cycle
// ---------------------------------------------------------------------------
`include "pcm_voice_mixer_core_defines.svh"

module pcm_voice_mixer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [3:0]         req_channel,
   input  logic [15:0]        req_sample_address,
   input  logic [7:0]         req_sample_byte,
   input  logic [15:0]        req_lump_length,
   input  logic [15:0]        req_format,
   input  logic [15:0]        req_dmx_length,
   input  logic [15:0]        req_source_rate,
   input  logic [7:0]         req_pitch,
   input  logic [7:0]         req_volume,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_assigned_channel,
   output logic               rsp_playing,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);
   import pvm_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   pvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   pvm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_operation        (req_operation),
      .req_channel          (req_channel),
      .req_sample_address   (req_sample_address),
      .req_sample_byte      (req_sample_byte),
      .req_lump_length      (req_lump_length),
      .req_format           (req_format),
      .req_dmx_length       (req_dmx_length),
      .req_source_rate      (req_source_rate),
      .req_pitch            (req_pitch),
      .req_volume           (req_volume),
      .rsp_left_sample      (rsp_left_sample),
      .rsp_right_sample     (rsp_right_sample),
      .rsp_status           (rsp_status),
      .rsp_assigned_channel (rsp_assigned_channel),
      .rsp_playing          (rsp_playing)
   );

   // an accepted item keeps the block busy on the next cycle
   `PVM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the result strobe is a single cycle
   `PVM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   // a failed start never reports a voice
   `PVM_ASSERT_NOW(a_fail_no_voice, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_assigned_channel == 3'd0)
   // the mix output is only non-zero alongside a clean status and a low playing flag
   `PVM_ASSERT_NOW(a_mix_clean, clock, reset, rsp_valid && rsp_left_sample != 16'sd0, rsp_status == ST_OK && !rsp_playing)

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the pcm voice mixer core: a behavioural predictor
// tracks store, voices and output rate, and every strobed result is compared
// field by field against the oldest predicted result
// ---------------------------------------------------------------------------
module tb;
   import pvm_pkg::*;

   // spare operation codes, answered with all zeros
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   // written window that successful starts play from (wraps through zero)
   localparam logic [15:0] WIN_BASE  = 16'hFF00;
   localparam int          WIN_SIZE  = 768;
   localparam int          RATE_RESET = 22050;

   typedef struct {
      logic [2:0]  op;
      logic [3:0]  ch;
      logic [15:0] addr;
      logic [7:0]  byte_val;
      logic [15:0] lump;
      logic [15:0] fmt;
      logic [15:0] dlen;
      logic [15:0] rate;
      logic [7:0]  pitch;
      logic [7:0]  vol;
   } mixer_item_t;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [1:0]         status;
      logic [2:0]         voice;
      logic               playing;
   } mixer_answer_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_operation = '0;
   logic [3:0]         req_channel = '0;
   logic [15:0]        req_sample_address = '0;
   logic [7:0]         req_sample_byte = '0;
   logic [15:0]        req_lump_length = '0;
   logic [15:0]        req_format = '0;
   logic [15:0]        req_dmx_length = '0;
   logic [15:0]        req_source_rate = '0;
   logic [7:0]         req_pitch = '0;
   logic [7:0]         req_volume = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_left_sample;
   logic signed [15:0] rsp_right_sample;
   logic [1:0]         rsp_status;
   logic [2:0]         rsp_assigned_channel;
   logic               rsp_playing;
   logic               csr_write_enable = 1'b0;
   logic [15:0]        csr_write_data = '0;

   pcm_voice_mixer_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_channel(req_channel),
      .req_sample_address(req_sample_address), .req_sample_byte(req_sample_byte),
      .req_lump_length(req_lump_length), .req_format(req_format),
      .req_dmx_length(req_dmx_length), .req_source_rate(req_source_rate),
      .req_pitch(req_pitch), .req_volume(req_volume),
      .rsp_valid(rsp_valid), .rsp_left_sample(rsp_left_sample),
      .rsp_right_sample(rsp_right_sample), .rsp_status(rsp_status),
      .rsp_assigned_channel(rsp_assigned_channel), .rsp_playing(rsp_playing),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // predictor state
   logic [7:0]  store_img [0:65535];
   bit          store_written [0:65535];
   bit          v_active [VOICES];
   logic [31:0] v_pos [VOICES];
   logic [19:0] v_step [VOICES];
   logic [15:0] v_count [VOICES];
   logic [15:0] v_base [VOICES];
   logic [7:0]  v_vol [VOICES];
   logic [15:0] out_rate = RATE_RESET;

   mixer_answer_t pending_answers [$];
   int errors = 0;
   int idle_pct = 0;
   int n_mix = 0, n_started = 0, n_refused = 0, n_clipped = 0, n_cfg = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // header check without side effects; picks the voice a start would take
   function automatic logic [1:0] start_verdict(input mixer_item_t it, output int vc);
      vc = it.ch;
      if (vc >= VOICES) begin
         vc = VOICES;
         for (int i = VOICES - 1; i >= 0; i--) if (!v_active[i]) vc = i;
      end
      if (vc >= VOICES) return ST_NO_VOICE;
      if (it.lump < 8 || it.fmt != 16'd3) return ST_BAD_HDR;
      if (it.dlen > it.lump - 16'd8 || it.dlen < 16'd49) return ST_BAD_HDR;
      if (it.rate == 0 || it.rate > 16'd48000) return ST_BAD_RATE;
      return ST_OK;
   endfunction

   // one mix tick across all voices, saturating after each voice
   function automatic logic signed [15:0] mix_voices();
      int acc, smp, p;
      acc = 0;
      for (int i = 0; i < VOICES; i++) begin
         if (!v_active[i]) continue;
         p = v_pos[i] >> 16;
         if (p >= v_count[i]) begin
            v_active[i] = 1'b0;
            continue;
         end
         smp = (int'(store_img[16'(v_base[i] + p)]) - 128) * 256;
         acc += (smp * int'(v_vol[i])) / 256;
         if (acc > 32767) acc = 32767;
         else if (acc < -32768) acc = -32768;
         v_pos[i] += v_step[i];
      end
      if (acc == 32767 || acc == -32768) n_clipped++;
      return acc[15:0];
   endfunction

   function automatic mixer_answer_t predict_answer(input mixer_item_t it);
      mixer_answer_t a;
      int vc;
      longint unsigned actual, stp, dv;
      logic [7:0] pt;
      a = '{default: '0};
      case (it.op)
         OP_LOAD: begin
            store_img[it.addr] = it.byte_val;
            store_written[it.addr] = 1'b1;
         end
         OP_START: begin
            a.status = start_verdict(it, vc);
            if (a.status == ST_OK) begin
               pt = (it.pitch == 0) ? 8'd128 : it.pitch;
               dv = (out_rate == 0) ? 1 : out_rate;
               actual = (longint'(it.rate) * pt) / 128;
               stp = (actual << 16) / dv;
               if (stp == 0) stp = 1;
               if (stp > 20'hFFFFF) stp = 20'hFFFFF;
               v_base[vc] = it.addr + 16'd24;
               v_count[vc] = it.dlen - 16'd32;
               v_pos[vc] = '0;
               v_step[vc] = stp[19:0];
               v_vol[vc] = it.vol;
               v_active[vc] = 1'b1;
               a.voice = vc[2:0];
               n_started++;
            end else begin
               n_refused++;
            end
         end
         OP_VOLUME: if (it.ch < VOICES) v_vol[it.ch[2:0]] = it.vol;
         OP_STOP:   if (it.ch < VOICES) v_active[it.ch[2:0]] = 1'b0;
         OP_QUERY:  if (it.ch < VOICES) a.playing = v_active[it.ch[2:0]];
         OP_MIX: begin
            a.left = mix_voices();
            n_mix++;
         end
         default: ;
      endcase
      a.right = a.left;
      return a;
   endfunction

   // result checker: every strobe is matched against the oldest prediction
   function automatic void report_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      mixer_answer_t e;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected result expected none actual %h", $time,
                     rsp_left_sample);
            errors++;
         end else begin
            e = pending_answers.pop_front();
            report_field("left_sample", e.left, rsp_left_sample);
            report_field("right_sample", e.right, rsp_right_sample);
            report_field("status", 16'(e.status), 16'(rsp_status));
            report_field("assigned_channel", 16'(e.voice), 16'(rsp_assigned_channel));
            report_field("playing", 16'(e.playing), 16'(rsp_playing));
         end
      end
   end

   // send one item: random idle first, then hold until accepted; start stays
   // high after acceptance while busy masks it, and is dropped by the caller
   task automatic send_item(input mixer_item_t it);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_operation = it.op;
      req_channel = it.ch;
      req_sample_address = it.addr;
      req_sample_byte = it.byte_val;
      req_lump_length = it.lump;
      req_format = it.fmt;
      req_dmx_length = it.dlen;
      req_source_rate = it.rate;
      req_pitch = it.pitch;
      req_volume = it.vol;
      start = 1'b1;
      do @(posedge clock); while (busy);
      pending_answers.push_back(predict_answer(it));
      @(negedge clock);
   endtask

   // let every outstanding item finish
   task automatic drain();
      start = 1'b0;
      while (pending_answers.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_rate(input logic [15:0] rate);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data = rate;
      @(negedge clock);
      csr_write_enable = 1'b0;
      out_rate = rate;
      n_cfg++;
   endtask

   function automatic mixer_item_t blank_item(input logic [2:0] op);
      mixer_item_t it;
      it = '{op: op, ch: 4'd0, addr: '0, byte_val: '0, lump: '0, fmt: '0, dlen: '0,
             rate: '0, pitch: '0, vol: '0};
      return it;
   endfunction

   // well-formed header playing from the written window
   function automatic mixer_item_t good_start(input logic [3:0] ch, input int cnt,
                                              input int offs);
      mixer_item_t it;
      it = blank_item(OP_START);
      it.ch = ch;
      it.dlen = 16'(cnt + 32);
      it.lump = 16'(it.dlen + 8 + $urandom_range(40));
      it.fmt = 16'd3;
      it.addr = 16'(WIN_BASE + offs - 24);
      it.rate = 16'($urandom_range(1, 48000));
      it.pitch = 8'($urandom);
      it.vol = 8'($urandom);
      return it;
   endfunction

   // store window: saturating highs, saturating lows, then random content
   task automatic test_store_fill();
      mixer_item_t it;
      for (int i = 0; i < WIN_SIZE; i++) begin
         it = blank_item(OP_LOAD);
         it.addr = 16'(WIN_BASE + i);
         it.byte_val = (i < 64) ? 8'hFF : (i < 128) ? 8'h00 : 8'($urandom);
         send_item(it);
      end
   endtask

   // status codes in check order, voice picking, saturation, stop and query
   task automatic test_directed();
      mixer_item_t it;
      for (int v = 0; v < VOICES; v++) begin
         it = good_start(4'(8 + v), 17, 0);
         it.vol = 8'hFF;
         it.pitch = 8'd0;
         it.rate = (v == 0) ? 16'd48000 : 16'd1;
         send_item(it);
      end
      // all voices busy: no free voice wins over a bad header
      it = blank_item(OP_START);
      it.ch = 4'd15;
      send_item(it);
      send_item(blank_item(OP_MIX));
      // named voice retaken while active, lows drive negative saturation
      for (int v = 0; v < VOICES; v++) begin
         it = good_start(4'(v), 17, 64);
         it.vol = 8'hFF;
         it.rate = 16'd1;
         send_item(it);
      end
      send_item(blank_item(OP_MIX));
      it = blank_item(OP_VOLUME); it.ch = 4'd3; it.vol = 8'h00; send_item(it);
      it = blank_item(OP_VOLUME); it.ch = 4'd12; it.vol = 8'hFF; send_item(it);
      it = blank_item(OP_STOP); it.ch = 4'd2; send_item(it);
      it = blank_item(OP_STOP); it.ch = 4'd9; send_item(it);
      it = blank_item(OP_QUERY); it.ch = 4'd2; send_item(it);
      it = blank_item(OP_QUERY); it.ch = 4'd1; send_item(it);
      it = blank_item(OP_QUERY); it.ch = 4'd15; send_item(it);
      send_item(blank_item(OP_SPARE_6));
      send_item(blank_item(OP_SPARE_7));
      // header faults into the free voice: short lump, format, lengths, rates
      it = good_start(4'd8, 17, 0); it.lump = 16'd7; send_item(it);
      it = good_start(4'd8, 17, 0); it.fmt = 16'hFFFF; send_item(it);
      it = good_start(4'd8, 17, 0); it.dlen = 16'hFFFF; send_item(it);
      it = good_start(4'd8, 17, 0); it.dlen = 16'd48; send_item(it);
      it = good_start(4'd8, 17, 0); it.rate = 16'd0; send_item(it);
      it = good_start(4'd8, 17, 0); it.rate = 16'd48001; send_item(it);
      it = good_start(4'd8, 17, 0); it.rate = 16'hFFFF; send_item(it);
      it = good_start(4'd2, 17, 0); it.pitch = 8'hFF; it.rate = 16'd48000; send_item(it);
      drain();
   endtask

   function automatic mixer_item_t random_item();
      mixer_item_t it;
      int pick, vc, cnt;
      bit clean;
      pick = $urandom_range(99);
      it = blank_item(OP_MIX);
      it.ch = 4'($urandom);
      it.vol = 8'($urandom);
      if (pick < 15) begin
         it.op = OP_LOAD;
         it.addr = 16'($urandom);
         it.byte_val = 8'($urandom);
      end else if (pick < 37) begin
         if ($urandom_range(99) < 80) begin
            it = good_start(4'($urandom), $urandom_range(17, 260), 0);
            if ($urandom_range(9) == 0) it.rate = 16'($urandom_range(1, 200));
         end else begin
            it.op = OP_START;
            it.addr = 16'($urandom); it.lump = 16'($urandom); it.fmt = 16'($urandom);
            it.dlen = 16'($urandom); it.rate = 16'($urandom); it.pitch = 8'($urandom);
            if ($urandom_range(1)) it.fmt = 16'd3;
         end
         // a start that would play must read only written bytes
         if (start_verdict(it, vc) == ST_OK) begin
            if (it.dlen > 16'd300) it.dlen = 16'($urandom_range(49, 300));
            cnt = it.dlen - 32;
            clean = 1'b1;
            for (int k = 0; k < cnt; k++)
               if (!store_written[16'(it.addr + 24 + k)]) clean = 1'b0;
            if (!clean)
               it.addr = 16'(WIN_BASE + $urandom_range(0, WIN_SIZE - cnt) - 24);
         end
      end else if (pick < 44) begin
         it.op = OP_VOLUME;
      end else if (pick < 49) begin
         it.op = OP_STOP;
      end else if (pick < 56) begin
         it.op = OP_QUERY;
      end else if (pick < 58) begin
         it.op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      return it;
   endfunction

   // random traffic in three idling phases
   task automatic test_random(input int n);
      int pcts [3] = '{0, 46, 16};
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = pcts[ph];
         for (int i = 0; i < n / 3; i++) send_item(random_item());
      end
      idle_pct = 0;
   endtask

   // output rate sweep: reset value, extremes, zero and a random setting
   task automatic test_rate_sweep();
      logic [15:0] rates [5] = '{16'd8000, 16'd48000, 16'd0, 16'hFFFF, 16'd0};
      rates[4] = 16'($urandom_range(8000, 48000));
      test_random(180);
      foreach (rates[r]) begin
         write_rate(rates[r]);
         test_random(180);
      end
      write_rate(16'(RATE_RESET));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_store_fill();
      test_directed();
      test_rate_sweep();
      drain();
      repeat (60) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $display("%0t %0d predicted results never arrived", $time, pending_answers.size());
         errors++;
      end
      $display("covered %0d mix ticks (%0d at a rail), %0d voice starts, %0d refused",
               n_mix, n_clipped, n_started, n_refused);
      $display("across %0d output rate writes, %0d errors", n_cfg, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/pvm_pkg.sv
rtl/pvm_datapath.sv
rtl/pvm_ctrl.sv
rtl/pcm_voice_mixer_core.sv
test/tb.sv
